// File: hdl/seven_segment_frame_composer_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef SEVEN_SEGMENT_FRAME_COMPOSER_UNIT_ASSERT_SVH
`define SEVEN_SEGMENT_FRAME_COMPOSER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define SSFC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssfc: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define SSFC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssfc: next-cycle check failed");

`endif

// File: hdl/ssfc_pkg.sv
`default_nettype none

package ssfc_pkg;

  typedef enum logic [2:0] {
    CMD_NUMBER = 3'd0,
    CMD_TIME   = 3'd1,
    CMD_DATE   = 3'd2,
    CMD_TEMP   = 3'd3,
    CMD_BRIGHT = 3'd4,
    CMD_CLEAR  = 3'd5,
    CMD_HELLO  = 3'd6
  } cmd_t;

  localparam logic [15:0] BLINK_RESET = 16'd1000;

  localparam logic [13:0] NUM_MAX   = 14'd9999;
  localparam logic [13:0] TEMP_MAX  = 14'd999;
  localparam logic [6:0]  PAIR_MAX  = 7'd99;
  localparam logic [13:0] LVL_LIMIT = 14'd7;

  // reciprocals: x/1000 = (x*R)>>23, x/100 = (x*R)>>20, x/10 = (x*R)>>19, for x <= 9999
  localparam logic [13:0] RECIP_1000 = 14'd8389;
  localparam logic [13:0] RECIP_100  = 14'd10486;
  localparam logic [15:0] RECIP_10   = 16'd52429;

  localparam logic [7:0] ADDR_BASE    = 8'hC0;
  localparam logic [7:0] DOT_BIT      = 8'h80;
  localparam logic [7:0] LVL_BASE     = 8'h88;
  localparam logic [7:0] LVL_MAX      = 8'h8F;
  localparam logic [7:0] MODE_FIXED   = 8'h44;
  localparam logic [7:0] DEGREE_GLYPH = 8'h63;
  localparam logic [7:0] GLYPH_H      = 8'h76;
  localparam logic [7:0] GLYPH_E      = 8'h79;
  localparam logic [7:0] GLYPH_L      = 8'h38;
  localparam logic [7:0] GLYPH_O      = 8'h3F;
  localparam logic [7:0] BLANK        = 8'h00;

  typedef struct packed {
    cmd_t        cmd;
    logic [13:0] val;       // saturated number or temperature tenths
    logic [3:0]  q1000;
    logic [6:0]  q100;
    logic [9:0]  q10;
    logic [6:0]  hi_pair;   // hours or day
    logic [3:0]  hi_tens;
    logic [6:0]  lo_pair;   // minutes or month
    logic [3:0]  lo_tens;
    logic        colon;
    logic [7:0]  lvl_byte;
  } split_t;

  // exact for x <= 1028
  function automatic logic [6:0] div10(input logic [9:0] x);
    logic [17:0] p;
    p = 18'(x) * 18'd205;
    return p[17:11];
  endfunction

  function automatic logic [3:0] mod10(input logic [9:0] x);
    logic [9:0] rem;
    rem = x - 10'(div10(x)) * 10'd10;
    return rem[3:0];
  endfunction

  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'h3F;
      4'd1: s = 8'h06;
      4'd2: s = 8'h5B;
      4'd3: s = 8'h4F;
      4'd4: s = 8'h66;
      4'd5: s = 8'h6D;
      4'd6: s = 8'h7D;
      4'd7: s = 8'h07;
      4'd8: s = 8'h7F;
      4'd9: s = 8'h6F;
      default: s = BLANK;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: hdl/ssfc_if.sv
`default_nettype none

interface ssfc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [13:0] first_value;
  logic [6:0]  second_value;
  logic [31:0] now_ms;

  modport source (output valid, output cmd, output first_value, output second_value,
                  output now_ms, input ready);
  modport sink (input valid, input cmd, input first_value, input second_value,
                input now_ms, output ready);
endinterface

interface ssfc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] bus_byte;
  logic       frame_start;
  logic       frame_end;
  logic       last_of_run;

  modport source (output valid, output bus_byte, output frame_start, output frame_end,
                  output last_of_run, input ready);
  modport sink (input valid, input bus_byte, input frame_start, input frame_end,
                input last_of_run, output ready);
endinterface

`default_nettype wire

// File: hdl/seven_segment_frame_composer_unit.sv
// Path: a request is registered in s0 and s1 of the front, then in the serializer buffer and the output register.
// Throughput: one bus byte per cycle from the byte serializer while out_ch is not stalled, 8 bytes per request
// (2 for brightness); an unused command code is dropped in the front and sends no bytes.
// Reset (rst, synchronous): pipeline and serializer empty, colon off, last toggle time 0,
// blink period 1000 ms.
`default_nettype none

module seven_segment_frame_composer_unit import ssfc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,
  ssfc_in_if.sink      in_ch,
  ssfc_out_if.source   out_ch
);

  logic [15:0] blink_period_ms;
  logic        split_valid;
  logic        split_ready;
  split_t      split_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_period_ms <= BLINK_RESET;
    end else if (cfg_wr_en) begin
      blink_period_ms <= cfg_wr_data;
    end
  end

  ssfc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .blink_period_ms (blink_period_ms),
    .in_ch           (in_ch),
    .dn_valid        (split_valid),
    .dn_ready        (split_ready),
    .dn_data         (split_data)
  );

  ssfc_serializer u_serializer (
    .clk      (clk),
    .rst      (rst),
    .up_valid (split_valid),
    .up_ready (split_ready),
    .up_data  (split_data),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

// File: hdl/ssfc_front.sv
`default_nettype none

module ssfc_front import ssfc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic [15:0]   blink_period_ms,
  ssfc_in_if.sink       in_ch,
  output logic          dn_valid,
  input  logic          dn_ready,
  output split_t        dn_data
);

  logic        s0_valid;
  logic [2:0]  s0_cmd;
  logic [13:0] s0_v1;
  logic [6:0]  s0_v2;
  logic [31:0] s0_now;

  logic        s1_valid;
  split_t      s1_data;

  logic        s0_adv;
  logic        s0_take;
  logic        cmd_ok;
  cmd_t        s0_kind;

  logic        colon_on;
  logic        colon_on_next;
  logic [31:0] last_toggle_ms;
  logic [31:0] last_toggle_ms_next;
  logic [31:0] elapsed;
  logic        toggle;

  logic [13:0] sat_val;
  logic [27:0] p1000;
  logic [27:0] p100;
  logic [29:0] p10;
  logic [6:0]  hi_pair;
  logic [6:0]  lo_pair;
  logic [6:0]  hi_q;
  logic [6:0]  lo_q;
  split_t      split_next;

  assign s0_adv      = s0_valid && (!s1_valid || dn_ready);
  assign in_ch.ready = !s0_valid || s0_adv;
  assign s0_take     = in_ch.valid && in_ch.ready;
  assign s0_kind     = cmd_t'(s0_cmd);
  assign cmd_ok      = (s0_cmd <= 3'(CMD_HELLO));

  assign dn_valid = s1_valid;
  assign dn_data  = s1_data;

  // colon flips only on time requests once the blink period is exceeded
  assign elapsed = s0_now - last_toggle_ms;
  assign toggle  = s0_adv && (s0_kind == CMD_TIME) && (elapsed > {16'd0, blink_period_ms});

  always_comb begin
    colon_on_next       = colon_on;
    last_toggle_ms_next = last_toggle_ms;
    if (toggle) begin
      colon_on_next       = !colon_on;
      last_toggle_ms_next = s0_now;
    end
  end

  always_comb begin
    if (s0_kind == CMD_TEMP) begin
      sat_val = (s0_v1 > TEMP_MAX) ? TEMP_MAX : s0_v1;
    end else begin
      sat_val = (s0_v1 > NUM_MAX) ? NUM_MAX : s0_v1;
    end
    hi_pair = (s0_v1 > 14'(PAIR_MAX)) ? PAIR_MAX : s0_v1[6:0];
    lo_pair = (s0_v2 > PAIR_MAX) ? PAIR_MAX : s0_v2;
    hi_q    = div10({3'd0, hi_pair});
    lo_q    = div10({3'd0, lo_pair});

    p1000 = 28'(sat_val) * 28'(RECIP_1000);
    p100  = 28'(sat_val) * 28'(RECIP_100);
    p10   = 30'(sat_val) * 30'(RECIP_10);

    split_next.cmd      = s0_kind;
    split_next.val      = sat_val;
    split_next.q1000    = p1000[26:23];
    split_next.q100     = p100[26:20];
    split_next.q10      = p10[28:19];
    split_next.hi_pair  = hi_pair;
    split_next.hi_tens  = hi_q[3:0];
    split_next.lo_pair  = lo_pair;
    split_next.lo_tens  = lo_q[3:0];
    split_next.colon    = colon_on_next;
    split_next.lvl_byte = (s0_v1 >= LVL_LIMIT) ? LVL_MAX : LVL_BASE + {5'd0, s0_v1[2:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid       <= 1'b0;
      s1_valid       <= 1'b0;
      colon_on       <= 1'b0;
      last_toggle_ms <= '0;
    end else begin
      colon_on       <= colon_on_next;
      last_toggle_ms <= last_toggle_ms_next;
      if (s0_take) begin
        s0_valid <= 1'b1;
      end else if (s0_adv) begin
        s0_valid <= 1'b0;
      end
      // drop unused command codes here
      if (s0_adv) begin
        s1_valid <= cmd_ok;
      end else if (dn_ready) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_take) begin
      s0_cmd <= in_ch.cmd;
      s0_v1  <= in_ch.first_value;
      s0_v2  <= in_ch.second_value;
      s0_now <= in_ch.now_ms;
    end
    if (s0_adv) begin
      s1_data <= split_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/ssfc_serializer.sv
`default_nettype none

module ssfc_serializer import ssfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        up_valid,
  output logic        up_ready,
  input  split_t      up_data,
  ssfc_out_if.source  out_ch
);

  logic [7:0] pat [4];
  logic [7:0] pat_next [4];
  logic       bright_next;
  logic       buf_valid;
  logic       buf_bright;
  logic [2:0] idx;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_start;
  logic       out_end;
  logic       out_last;

  logic       emit;
  logic       last_byte;
  logic       load;
  logic [7:0] byte_sel;
  logic       start_sel;
  logic       end_sel;

  logic [3:0]  d_hund;
  logic [3:0]  d_tens;
  logic [13:0] u_rem;
  logic [6:0]  hi_rem;
  logic [6:0]  lo_rem;
  logic [7:0]  dot_time;

  always_comb begin
    d_hund   = mod10({3'd0, up_data.q100});
    d_tens   = mod10(up_data.q10);
    u_rem    = up_data.val - 14'(up_data.q10) * 14'd10;
    hi_rem   = up_data.hi_pair - 7'(up_data.hi_tens) * 7'd10;
    lo_rem   = up_data.lo_pair - 7'(up_data.lo_tens) * 7'd10;
    dot_time = up_data.colon ? DOT_BIT : BLANK;

    bright_next = 1'b0;
    pat_next[0] = BLANK;
    pat_next[1] = BLANK;
    pat_next[2] = BLANK;
    pat_next[3] = BLANK;
    case (up_data.cmd)
      CMD_NUMBER: begin
        pat_next[0] = seg_of(up_data.q1000);
        pat_next[1] = seg_of(d_hund);
        pat_next[2] = seg_of(d_tens);
        pat_next[3] = seg_of(u_rem[3:0]);
      end
      CMD_TIME: begin
        pat_next[0] = seg_of(up_data.hi_tens);
        pat_next[1] = seg_of(hi_rem[3:0]) | dot_time;
        pat_next[2] = seg_of(up_data.lo_tens);
        pat_next[3] = seg_of(lo_rem[3:0]);
      end
      CMD_DATE: begin
        pat_next[0] = seg_of(up_data.hi_tens);
        pat_next[1] = seg_of(hi_rem[3:0]) | DOT_BIT;
        pat_next[2] = seg_of(up_data.lo_tens);
        pat_next[3] = seg_of(lo_rem[3:0]);
      end
      CMD_TEMP: begin
        pat_next[0] = seg_of(d_hund);
        pat_next[1] = seg_of(d_tens) | DOT_BIT;
        pat_next[2] = seg_of(u_rem[3:0]);
        pat_next[3] = DEGREE_GLYPH;
      end
      CMD_BRIGHT: begin
        bright_next = 1'b1;
        pat_next[0] = up_data.lvl_byte;
        pat_next[1] = MODE_FIXED;
      end
      CMD_CLEAR: begin
        pat_next[0] = BLANK;
      end
      CMD_HELLO: begin
        pat_next[0] = GLYPH_H;
        pat_next[1] = GLYPH_E;
        pat_next[2] = GLYPH_L;
        pat_next[3] = GLYPH_O;
      end
      default: begin
        pat_next[0] = BLANK;
      end
    endcase
  end

  assign last_byte = buf_bright ? (idx == 3'd1) : (idx == 3'd7);
  assign emit      = buf_valid && (!out_valid || out_ch.ready);
  assign up_ready  = !buf_valid || (emit && last_byte);
  assign load      = up_valid && up_ready;

  // brightness bytes are one-byte frames; others alternate address and pattern
  always_comb begin
    if (buf_bright) begin
      byte_sel  = pat[{1'b0, idx[0]}];
      start_sel = 1'b1;
      end_sel   = 1'b1;
    end else if (!idx[0]) begin
      byte_sel  = ADDR_BASE + 8'(idx[2:1]);
      start_sel = 1'b1;
      end_sel   = 1'b0;
    end else begin
      byte_sel  = pat[idx[2:1]];
      start_sel = 1'b0;
      end_sel   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      // a new request replaces the one whose last byte leaves this cycle
      if (load) begin
        buf_valid <= 1'b1;
        idx       <= '0;
      end else if (emit) begin
        idx <= idx + 3'd1;
        if (last_byte) begin
          buf_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pat[0]     <= pat_next[0];
      pat[1]     <= pat_next[1];
      pat[2]     <= pat_next[2];
      pat[3]     <= pat_next[3];
      buf_bright <= bright_next;
    end
    if (emit) begin
      out_byte  <= byte_sel;
      out_start <= start_sel;
      out_end   <= end_sel;
      out_last  <= last_byte;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.bus_byte    = out_byte;
  assign out_ch.frame_start = out_start;
  assign out_ch.frame_end   = out_end;
  assign out_ch.last_of_run = out_last;

endmodule

`default_nettype wire

// File: hdl/ssfc_checker.sv
`default_nettype none
`include "seven_segment_frame_composer_unit_assert.svh"

module ssfc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] bus_byte,
  input logic       frame_start,
  input logic       frame_end,
  input logic       last_of_run
);

  // a stalled byte holds
  `SSFC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(bus_byte) && $stable(frame_start) && $stable(frame_end) && $stable(last_of_run))

  // a frame that stays open is a digit address
  `SSFC_ASSERT_IMP(a_addr_byte, out_valid && frame_start && !frame_end, bus_byte[7:2] == 6'b110000)

  // single-byte frames are brightness or mode commands
  `SSFC_ASSERT_IMP(a_single_frame, out_valid && frame_start && frame_end, bus_byte[7:4] == 4'h8 || bus_byte == 8'h44)

  // a run always closes its frame
  `SSFC_ASSERT_IMP(a_last_closes, out_valid && last_of_run, frame_end)

endmodule

bind seven_segment_frame_composer_unit ssfc_checker u_ssfc_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .bus_byte    (out_ch.bus_byte),
  .frame_start (out_ch.frame_start),
  .frame_end   (out_ch.frame_end),
  .last_of_run (out_ch.last_of_run)
);

`default_nettype wire

// File: dv/seven_segment_frame_composer_unit_tb.sv
`timescale 1ns / 1ps

module seven_segment_frame_composer_unit_tb;
  import ssfc_pkg::*;

  localparam logic [2:0] CMD_SPARE = 3'd7;
  localparam int MAX_IDLE = 16;
  localparam int HALF_PHASE = 50;
  localparam int PHASE_COUNT = 5;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       frame_start;
    logic       frame_end;
    logic       last_of_run;
  } bus_frame_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [13:0] first_value;
    logic [6:0]  second_value;
    logic [31:0] now_ms;
    logic        typed;
    logic [31:0] glyphs;
  } request_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  ssfc_in_if  req_ch ();
  ssfc_out_if bus_ch ();

  seven_segment_frame_composer_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (req_ch),
    .out_ch      (bus_ch)
  );

  // predictor state
  logic        colon_lit;
  logic [31:0] last_toggle_at;
  logic [15:0] blink_period;

  bus_frame_t  pending_frames [$];
  int          error_count;
  int          bytes_checked;
  int          requests_sent;
  int          colon_flips;
  bit          no_idle;
  logic [31:0] clock_ms;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int draw_idle();
    return no_idle ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  function automatic logic [7:0] digit_glyph(input int unsigned d);
    logic [7:0] g;
    case (d)
      0: g = 8'h3F;
      1: g = 8'h06;
      2: g = 8'h5B;
      3: g = 8'h4F;
      4: g = 8'h66;
      5: g = 8'h6D;
      6: g = 8'h7D;
      7: g = 8'h07;
      8: g = 8'h7F;
      default: g = 8'h6F;
    endcase
    return g;
  endfunction

  // Four display patterns, left to right; brightness uses the top two bytes.
  // Updates the colon state for time requests.
  function automatic logic [31:0] compose_glyphs(input logic [2:0] cmd,
                                                 input logic [13:0] v1,
                                                 input logic [6:0] v2,
                                                 input logic [31:0] now);
    int unsigned a;
    int unsigned b;
    logic        dot;
    logic [31:0] g;
    a = v1;
    b = v2;
    dot = 1'b1;
    g = '0;
    case (cmd)
      CMD_NUMBER: begin
        a = (a > 9999) ? 9999 : a;
        g = {digit_glyph(a / 1000), digit_glyph((a / 100) % 10),
             digit_glyph((a / 10) % 10), digit_glyph(a % 10)};
      end
      CMD_TIME, CMD_DATE: begin
        if (cmd == CMD_TIME) begin
          if (now - last_toggle_at > {16'd0, blink_period}) begin
            colon_lit = !colon_lit;
            last_toggle_at = now;
            colon_flips++;
          end
          dot = colon_lit;
        end
        a = (a > 99) ? 99 : a;
        b = (b > 99) ? 99 : b;
        g = {digit_glyph(a / 10), digit_glyph(a % 10) | (dot ? DOT_BIT : BLANK),
             digit_glyph(b / 10), digit_glyph(b % 10)};
      end
      CMD_TEMP: begin
        a = (a > 999) ? 999 : a;
        g = {digit_glyph(a / 100), digit_glyph((a / 10) % 10) | DOT_BIT,
             digit_glyph(a % 10), DEGREE_GLYPH};
      end
      CMD_BRIGHT: g = {(v1 >= 14'd7) ? LVL_MAX : LVL_BASE + 8'(v1), MODE_FIXED, 16'h0};
      CMD_CLEAR:  g = {BLANK, BLANK, BLANK, BLANK};
      CMD_HELLO:  g = {GLYPH_H, GLYPH_E, GLYPH_L, GLYPH_O};
      default:    g = '0;
    endcase
    return g;
  endfunction

  task automatic queue_frames(input logic [2:0] cmd, input logic [31:0] glyphs);
    if (cmd == CMD_BRIGHT) begin
      pending_frames.push_back({glyphs[31:24], 1'b1, 1'b1, 1'b0});
      pending_frames.push_back({glyphs[23:16], 1'b1, 1'b1, 1'b1});
    end else if (cmd != CMD_SPARE) begin
      for (int k = 0; k < 4; k++) begin
        pending_frames.push_back({ADDR_BASE + 8'(k), 1'b1, 1'b0, 1'b0});
        pending_frames.push_back({glyphs[8 * (3 - k) +: 8], 1'b0, 1'b1, k == 3});
      end
    end
  endtask

  // Leaves valid high after the transfer; the next call replaces or lowers it, or a drain takes it down.
  task automatic send_request(input logic [2:0] cmd, input logic [13:0] v1,
                              input logic [6:0] v2, input logic [31:0] now,
                              input logic typed, input logic [31:0] typed_glyphs);
    int          gap;
    logic [31:0] glyphs;
    gap = draw_idle();
    @(negedge clk);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.cmd          <= cmd;
    req_ch.first_value  <= v1;
    req_ch.second_value <= v2;
    req_ch.now_ms       <= now;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    glyphs = compose_glyphs(cmd, v1, v2, now);
    queue_frames(cmd, typed ? typed_glyphs : glyphs);
    requests_sent++;
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
  endtask

  task automatic write_blink_period(input logic [15:0] period);
    hold_until_drained();
    // a dropped spare command may still be in flight
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_data <= period;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    blink_period = period;
  endtask

  // bus byte receiver and checker
  initial begin
    bus_frame_t got;
    bus_frame_t want;
    int         stall;
    do @(negedge clk); while (rst !== 1'b0);
    forever begin
      stall = draw_idle();
      if (stall != 0) begin
        bus_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      bus_ch.ready <= 1'b1;
      do @(posedge clk); while (bus_ch.valid !== 1'b1);
      got = {bus_ch.bus_byte, bus_ch.frame_start, bus_ch.frame_end, bus_ch.last_of_run};
      if (pending_frames.size() == 0) begin
        $display("%0t: unexpected bus byte: expected none, actual %h", $time, got);
        error_count++;
      end else begin
        want = pending_frames.pop_front();
        bytes_checked++;
        if (got.bus_byte !== want.bus_byte) begin
          $display("%0t: bus_byte expected %h actual %h", $time, want.bus_byte, got.bus_byte);
          error_count++;
        end
        if (got.frame_start !== want.frame_start) begin
          $display("%0t: frame_start expected %b actual %b", $time,
                   want.frame_start, got.frame_start);
          error_count++;
        end
        if (got.frame_end !== want.frame_end) begin
          $display("%0t: frame_end expected %b actual %b", $time,
                   want.frame_end, got.frame_end);
          error_count++;
        end
        if (got.last_of_run !== want.last_of_run) begin
          $display("%0t: last_of_run expected %b actual %b", $time,
                   want.last_of_run, got.last_of_run);
          error_count++;
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    request_row_t directed_rows [$];
    request_row_t row;
    logic [2:0]   cmd;
    logic [13:0]  v1;
    logic [6:0]   v2;
    logic [15:0]  period;
    int           counted;
    int unsigned  pick;

    rst          <= 1'b1;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    req_ch.valid <= 1'b0;
    req_ch.cmd   <= '0;
    req_ch.first_value  <= '0;
    req_ch.second_value <= '0;
    req_ch.now_ms       <= '0;
    bus_ch.ready <= 1'b0;
    colon_lit      = 1'b0;
    last_toggle_at = '0;
    blink_period   = BLINK_RESET;
    error_count    = 0;
    bytes_checked  = 0;
    requests_sent  = 0;
    colon_flips    = 0;
    no_idle        = 1'b0;

    directed_rows.push_back('{CMD_NUMBER, 14'd0,     7'd0,   32'd0,  1'b1, 32'h3F3F3F3F});
    directed_rows.push_back('{CMD_NUMBER, 14'd9999,  7'd0,   32'd0,  1'b1, 32'h6F6F6F6F});
    directed_rows.push_back('{CMD_NUMBER, 14'd16383, 7'd127, 32'd0,  1'b1, 32'h6F6F6F6F});
    directed_rows.push_back('{CMD_NUMBER, 14'd1234,  7'd0,   32'd0,  1'b0, 32'h0});
    // colon: no change at equal time, toggle just past the period, hold at exactly it
    directed_rows.push_back('{CMD_TIME,   14'd0,     7'd0,   32'd0,  1'b1, 32'h3F3F3F3F});
    directed_rows.push_back('{CMD_TIME,   14'd12,    7'd34,  32'd1001, 1'b0, 32'h0});
    directed_rows.push_back('{CMD_TIME,   14'd23,    7'd59,  32'd2001, 1'b0, 32'h0});
    directed_rows.push_back('{CMD_TIME,   14'd16383, 7'd127, 32'hFFFF_FFFF, 1'b0, 32'h0});
    // counter wrap: small difference across zero
    directed_rows.push_back('{CMD_TIME,   14'd5,     7'd7,   32'd3,  1'b0, 32'h0});
    directed_rows.push_back('{CMD_DATE,   14'd0,     7'd0,   32'd0,  1'b1, 32'h3FBF3F3F});
    directed_rows.push_back('{CMD_DATE,   14'd16383, 7'd127, 32'd0,  1'b1, 32'h6FEF6F6F});
    directed_rows.push_back('{CMD_DATE,   14'd31,    7'd12,  32'd0,  1'b0, 32'h0});
    directed_rows.push_back('{CMD_TEMP,   14'd0,     7'd0,   32'd0,  1'b1, 32'h3FBF3F63});
    directed_rows.push_back('{CMD_TEMP,   14'd16383, 7'd127, 32'd0,  1'b1, 32'h6FEF6F63});
    directed_rows.push_back('{CMD_TEMP,   14'd235,   7'd0,   32'd0,  1'b0, 32'h0});
    directed_rows.push_back('{CMD_BRIGHT, 14'd0,     7'd0,   32'd0,  1'b1, 32'h88440000});
    directed_rows.push_back('{CMD_BRIGHT, 14'd6,     7'd0,   32'd0,  1'b1, 32'h8E440000});
    directed_rows.push_back('{CMD_BRIGHT, 14'd7,     7'd0,   32'd0,  1'b1, 32'h8F440000});
    directed_rows.push_back('{CMD_BRIGHT, 14'd16383, 7'd127, 32'd0,  1'b1, 32'h8F440000});
    directed_rows.push_back('{CMD_CLEAR,  14'd16383, 7'd127, 32'd0,  1'b1, 32'h00000000});
    directed_rows.push_back('{CMD_HELLO,  14'd0,     7'd0,   32'd0,  1'b1, 32'h7679383F});
    directed_rows.push_back('{CMD_SPARE,  14'd16383, 7'd127, 32'hFFFF_FFFF, 1'b1, 32'h0});
    directed_rows.push_back('{CMD_NUMBER, 14'd8,     7'd127, 32'd0,  1'b0, 32'h0});
    clock_ms = 32'd3;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_request(row.cmd, row.first_value, row.second_value, row.now_ms,
                   row.typed, row.glyphs);
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: period = 16'd0;
        1: period = 16'hFFFF;
        2: period = 16'd1;
        3: period = 16'($urandom_range(2, 5000));
        default: period = BLINK_RESET;
      endcase
      write_blink_period(period);
      no_idle = (p == 2);
      for (int half = 0; half < 2; half++) begin
        counted = 0;
        while (counted < HALF_PHASE) begin
          pick = $urandom_range(0, 15);
          if (pick < 5) cmd = CMD_TIME;
          else if (pick == 15) cmd = CMD_SPARE;
          else cmd = 3'($urandom_range(0, 6));
          if ($urandom_range(0, 4) == 0) begin
            v1 = 14'($urandom_range(0, 16383));
          end else begin
            case (cmd)
              CMD_NUMBER:         v1 = 14'($urandom_range(0, 9999));
              CMD_TIME, CMD_DATE: v1 = 14'($urandom_range(0, 99));
              CMD_TEMP:           v1 = 14'($urandom_range(0, 999));
              CMD_BRIGHT:         v1 = 14'($urandom_range(0, 7));
              default:            v1 = 14'($urandom_range(0, 16383));
            endcase
          end
          v2 = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                           : 7'($urandom_range(0, 99));
          // advance the millisecond count around the blink period, with jumps
          case ($urandom_range(0, 9))
            0: clock_ms = clock_ms;
            1: clock_ms = $urandom();
            default: clock_ms = clock_ms + $urandom_range(0, 2 * blink_period + 2);
          endcase
          send_request(cmd, v1, v2, clock_ms, 1'b0, 32'h0);
          if (cmd != CMD_SPARE) counted++;
        end
        hold_until_drained();
      end
    end

    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    $display("Sent %0d requests over %0d blink periods; checked %0d bus bytes.",
             requests_sent, PHASE_COUNT + 1, bytes_checked);
    $display("Colon toggled %0d times, periods from 0 to 65535 ms.", colon_flips);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: seven_segment_frame_composer_unit.f
+incdir+hdl
hdl/ssfc_pkg.sv
hdl/ssfc_if.sv
hdl/ssfc_front.sv
hdl/ssfc_serializer.sv
hdl/seven_segment_frame_composer_unit.sv
hdl/ssfc_checker.sv
dv/seven_segment_frame_composer_unit_tb.sv
